// ----- src/assert_macros.svh -----
// Assertion macros shared by the euler_to_quaternion RTL.
// Depends on nothing; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/etq_pkg.sv -----
// Package for the Euler-angle to quaternion converter.
// Holds the CORDIC constants, the lane result type and the Q1.15 rounding helper.
`timescale 1ns / 1ps

package etq_pkg;

  // CORDIC gain compensation, Q30
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032875;

  // Arctangent of 2^-i as a 32-bit binary angle
  localparam logic [31:0] ARC_TABLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Rounding constant for Q60 -> Q15 (2^44)
  localparam logic signed [63:0] HALF_Q45 = 64'sd17592186044416;

  // Cosine and sine of one half angle, Q30
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } trig_t;

  // Quaternion in Q1.15
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  // Round a Q60 value half up to Q15 and saturate
  function automatic logic signed [15:0] sat_q15(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + HALF_Q45) >>> 45;
    if (r > 64'sd32767) begin
      return 16'sh7fff;
    end else if (r < -64'sd32768) begin
      return 16'sh8000;
    end
    return 16'(r);
  endfunction

endpackage

// ----- src/etq_cordic_lane.sv -----
// One lane: pipelined rotation-mode CORDIC giving cos and sin of half an angle.
// Depends on etq_pkg (gain, arctangent table, trig_t).
`timescale 1ns / 1ps

module etq_cordic_lane #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output etq_pkg::trig_t         result
);

  // Scale the angle to 32 bits, then halve it (arithmetic shift keeps the sign)
  logic [31:0]        angle_t;
  logic signed [32:0] z_init;
  assign angle_t = 32'(angle) << (32 - ANGLE_WIDTH);
  assign z_init  = 33'($signed(angle_t) >>> 1);

  // One register set per micro-rotation
  logic signed [31:0] x_r [CORDIC_STEPS];
  logic signed [31:0] y_r [CORDIC_STEPS];
  logic signed [32:0] z_r [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [31:0] x_in, y_in, x_nx, y_nx;
    logic signed [32:0] z_in, z_nx, arc;

    if (k == 0) begin : g_first
      assign x_in = etq_pkg::GAIN_Q30;
      assign y_in = '0;
      assign z_in = z_init;
    end else begin : g_rest
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
    end

    assign arc = $signed({1'b0, etq_pkg::ARC_TABLE[k]});

    // Rotate towards zero residual angle
    always_comb begin
      if (z_in >= 0) begin
        x_nx = x_in - (y_in >>> k);
        y_nx = y_in + (x_in >>> k);
        z_nx = z_in - arc;
      end else begin
        x_nx = x_in + (y_in >>> k);
        y_nx = y_in - (x_in >>> k);
        z_nx = z_in + arc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= x_nx;
        y_r[k] <= y_nx;
        z_r[k] <= z_nx;
      end
    end
  end

  assign result.c = x_r[CORDIC_STEPS-1];
  assign result.s = y_r[CORDIC_STEPS-1];

endmodule

// ----- src/etq_merge.sv -----
// Merging stage: combines the three lanes' cos/sin into the quaternion.
// Depends on etq_pkg (trig_t, quat_t, sat_q15). Four register stages.
`timescale 1ns / 1ps

module etq_merge (
  input  logic           clk,
  input  logic           en,
  input  etq_pkg::trig_t tx,
  input  etq_pkg::trig_t ty,
  input  etq_pkg::trig_t tz,
  output etq_pkg::quat_t quat
);

  // Pair product rounded half up to Q30; magnitude stays below 2^31
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'((p + 64'sd536870912) >>> 30);
  endfunction

  // Stage 1: pair products of x and y lanes
  logic signed [31:0] p_cc, p_ss, p_sc, p_cs, cz1, sz1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_cc <= mul_q30(tx.c, ty.c);
      p_ss <= mul_q30(tx.s, ty.s);
      p_sc <= mul_q30(tx.s, ty.c);
      p_cs <= mul_q30(tx.c, ty.s);
      cz1  <= tz.c;
      sz1  <= tz.s;
    end
  end

  // Stage 2: triple products, Q60
  logic signed [63:0] t_w0, t_w1, t_x0, t_x1, t_y0, t_y1, t_z0, t_z1;
  always_ff @(posedge clk) begin
    if (en) begin
      t_w0 <= 64'(p_cc) * 64'(cz1);
      t_w1 <= 64'(p_ss) * 64'(sz1);
      t_x0 <= 64'(p_sc) * 64'(cz1);
      t_x1 <= 64'(p_cs) * 64'(sz1);
      t_y0 <= 64'(p_cs) * 64'(cz1);
      t_y1 <= 64'(p_sc) * 64'(sz1);
      t_z0 <= 64'(p_cc) * 64'(sz1);
      t_z1 <= 64'(p_ss) * 64'(cz1);
    end
  end

  // Stage 3: sums
  logic signed [63:0] s_w, s_x, s_y, s_z;
  always_ff @(posedge clk) begin
    if (en) begin
      s_w <= t_w0 + t_w1;
      s_x <= t_x0 - t_x1;
      s_y <= t_y0 + t_y1;
      s_z <= t_z0 - t_z1;
    end
  end

  // Stage 4: round to Q1.15 and saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      quat.w <= etq_pkg::sat_q15(s_w);
      quat.x <= etq_pkg::sat_q15(s_x);
      quat.y <= etq_pkg::sat_q15(s_y);
      quat.z <= etq_pkg::sat_q15(s_z);
    end
  end

endmodule

// ----- src/euler_to_quaternion.sv -----
// Euler angles (ZYX) to quaternion: three CORDIC lanes and a product merger.
// Fully pipelined; one beat per cycle sustained while no output beat is blocked.
// Throughput is set by the fully pipelined CORDIC lanes and merge multipliers.
// The whole pipeline holds while an output beat waits; reset clears valid bits only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module euler_to_quaternion #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // angle_x, angle_y, angle_z from bit 0 up, zero pad to whole bytes
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up
  output logic [63:0]                            m_tdata
);

  localparam int LATENCY = CORDIC_STEPS + 4;

  // Pipeline advances unless the output beat is blocked
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Valid bits, one per pipeline stage
  logic [LATENCY-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[LATENCY-1];

  // Three lanes, one per axis
  etq_pkg::trig_t trig_x, trig_y, trig_z;

  etq_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
    .clk(clk), .en(en), .angle(s_tdata[ANGLE_WIDTH-1:0]), .result(trig_x)
  );
  etq_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
    .clk(clk), .en(en), .angle(s_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]), .result(trig_y)
  );
  etq_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
    .clk(clk), .en(en), .angle(s_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]), .result(trig_z)
  );

  // Merge lanes into the quaternion
  etq_pkg::quat_t quat;
  etq_merge u_merge (
    .clk(clk), .en(en), .tx(trig_x), .ty(trig_y), .tz(trig_z), .quat(quat)
  );

  assign m_tdata = {quat.z, quat.y, quat.x, quat.w};

  // Checks
  `ASSERT_CLK(a_stall_blocks_input, clk, rst,
              (m_tvalid && !m_tready) |-> !s_tready, "input taken while output blocked")
  `ASSERT_CLK(a_out_from_pipe, clk, rst,
              $rose(m_tvalid) |-> $past(vld[LATENCY-2]), "output valid without preceding stage")
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (vld == '0), "valid bits not cleared by reset")

endmodule

// ----- dv/quat_checker.sv -----
`timescale 1ns / 1ps
// Checker for euler_to_quaternion: watches both stream channels, predicts each quaternion
// and compares it field by field. Depends on etq_pkg for the CORDIC constants and quat_t.
module quat_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // angle_x, angle_y, angle_z from bit 0 up
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up
  input  logic [63:0] m_tdata,
  output int          errors,
  output int          outstanding
);

  localparam int STEPS = 16;

  etq_pkg::quat_t quat_expected[$];
  string          field_name[4] = '{"quat_w", "quat_x", "quat_y", "quat_z"};

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  // Round half up from 2^sh units
  function automatic logic signed [63:0] round_down_by(input logic signed [63:0] v,
                                                       input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Cosine and sine (Q30) of half the binary angle, rotation-mode CORDIC
  function automatic void half_angle_trig(input logic [15:0] ang,
                                          output logic signed [63:0] c,
                                          output logic signed [63:0] s);
    logic        [31:0] turn;
    logic signed [63:0] resid, cx, sy, dx, dy;
    int i;
    turn  = {ang, 16'h0000};
    // halve, keeping the sign so that a half turn maps to -1/4 turn
    resid = {{33{turn[31]}}, turn[31:1]};
    cx    = etq_pkg::GAIN_Q30;
    sy    = 64'sd0;
    for (i = 0; i < STEPS; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (resid >= 0) begin
        cx    = cx - dx;
        sy    = sy + dy;
        resid = resid - $signed({32'd0, etq_pkg::ARC_TABLE[i]});
      end else begin
        cx    = cx + dx;
        sy    = sy - dy;
        resid = resid + $signed({32'd0, etq_pkg::ARC_TABLE[i]});
      end
    end
    c = cx;
    s = sy;
  endfunction

  // Three Q30 factors to Q60, pair product rounded back to Q30 first
  function automatic logic signed [63:0] triple_q60(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic signed [63:0] d);
    return round_down_by(a * b, 30) * d;
  endfunction

  // Q60 to saturated Q1.15
  function automatic logic [15:0] q60_to_q15(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = round_down_by(v, 45);
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r[15:0];
  endfunction

  function automatic etq_pkg::quat_t predict_quat(input logic [47:0] angles);
    logic signed [63:0] cx, sx, cy, sy, cz, sz;
    etq_pkg::quat_t q;
    half_angle_trig(angles[15:0],  cx, sx);
    half_angle_trig(angles[31:16], cy, sy);
    half_angle_trig(angles[47:32], cz, sz);
    q.w = q60_to_q15(triple_q60(cx, cy, cz) + triple_q60(sx, sy, sz));
    q.x = q60_to_q15(triple_q60(sx, cy, cz) - triple_q60(cx, sy, sz));
    q.y = q60_to_q15(triple_q60(cx, sy, cz) + triple_q60(sx, cy, sz));
    q.z = q60_to_q15(triple_q60(cx, cy, sz) - triple_q60(sx, sy, cz));
    return q;
  endfunction

  // Predict on each input beat, compare on each output beat
  always @(posedge clk) begin : monitor
    logic [63:0] want, got;
    int k;
    if (!rst) begin
      if (s_tvalid && s_tready) quat_expected.push_back(predict_quat(s_tdata));
      if (m_tvalid && m_tready) begin
        if (quat_expected.size() == 0) begin
          $error("output beat %h with no quaternion pending", m_tdata);
          errors++;
        end else begin
          want = quat_expected.pop_front();
          got  = m_tdata;
          for (k = 0; k < 4; k++) begin
            if (want[16*k +: 16] !== got[16*k +: 16]) begin
              $error("%s: expected %0d, got %0d", field_name[k],
                     $signed(want[16*k +: 16]), $signed(got[16*k +: 16]));
              errors++;
            end
          end
        end
      end
    end
    outstanding = quat_expected.size();
  end

endmodule

// ----- dv/tb_euler_to_quaternion.sv -----
`timescale 1ns / 1ps
// Top of the euler_to_quaternion bench: clock, reset, angle stimulus and output back-pressure.
// Depends on the RTL (etq_pkg, euler_to_quaternion) and on quat_checker for prediction.
module tb_euler_to_quaternion;

  localparam int N_RANDOM    = 1600;
  localparam int QUIET_FROM  = 1400;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 60;
  localparam int N_DIRECTED  = 18;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  logic s_taken = 1'b0;
  logic quiet   = 1'b0;
  logic hold_req = 1'b0;
  int   errors, outstanding;
  int   stuck = 0;

  // Directed angles: zero, half turns, full scale, quarter turns, bit patterns
  int dir_x[N_DIRECTED] = '{0, -32768, 0, 0, -32768, 32767, 16384, 0, 0, -16384,
                            1, -1, 21845, -21846, 8192, -32768, 32767, -8192};
  int dir_y[N_DIRECTED] = '{0, 0, -32768, 0, -32768, 32767, 0, 16384, 0, -16384,
                            -1, 1, 21845, -21846, 8192, 16384, -32767, 24576};
  int dir_z[N_DIRECTED] = '{0, 0, 0, -32768, -32768, 32767, 0, 0, 16384, -16384,
                            1, -1, 21845, -21846, 8192, -16384, 0, -24576};
  int near_edges[9] = '{-32768, -16384, -8192, 0, 8192, 16384, 32767, 1, -1};

  euler_to_quaternion dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  quat_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Input beat seen at the last rising edge
  always @(posedge clk) begin
    s_taken <= s_tvalid && s_tready;
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck <= 0;
    end else if (stuck >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Angle mostly uniform, sometimes close to zero, an eighth, a quarter or a half turn
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 7) == 0)
      return 16'(near_edges[$urandom_range(0, 8)] + int'($urandom_range(0, 4)) - 2);
    return 16'($urandom);
  endfunction

  // Offer one beat from a falling edge, with an optional gap first
  task automatic offer(input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                       input logic bursty);
    if (!quiet && bursty && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 48'({$urandom, $urandom});
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tdata  <= {az, ay, ax};
    s_tvalid <= 1'b1;
    do @(negedge clk); while (!s_taken);
  endtask

  // Sender and verdict
  initial begin
    int  i;
    logic bursty;
    bursty = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      offer(16'(dir_x[i]), 16'(dir_y[i]), 16'(dir_z[i]), 1'b1);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(0, 31) == 0) bursty = !bursty;
      offer(pick_angle(), pick_angle(), pick_angle(), bursty);
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: ready bursts and stalls, one long hold-off to fill the pipeline
  initial begin
    logic held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        if (!quiet && $urandom_range(0, 3) != 0) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/etq_pkg.sv
src/etq_cordic_lane.sv
src/etq_merge.sv
src/euler_to_quaternion.sv
dv/quat_checker.sv
dv/tb_euler_to_quaternion.sv
